// ===== src/tbpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-button press classifier package
// Shared widths, limits, register indexes and the structs that pass between
// the button lanes, the combo stage and the top level.
// ----------------------------------------------------------------------------
package tbpc_pkg;

    localparam int DEB_W   = 10;
    localparam int HOLD_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [DEB_W-1:0]  DEB_MAX  = {DEB_W{1'b1}};
    localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = DEB_W'(40);
    localparam logic [HOLD_W-1:0] LONG_RESET     = HOLD_W'(1200);
    localparam logic [HOLD_W-1:0] COMBO_RESET    = HOLD_W'(3000);

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBO    = 2'd2;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ticks;
        logic [HOLD_W-1:0] long_press_ticks;
        logic [HOLD_W-1:0] combo_hold_ticks;
    } t_cfg;

    // What one button lane reports for the current item.
    typedef struct packed {
        logic pressed;
        logic short_ev;
        logic long_ev;
    } t_lane_evt;

    typedef struct packed {
        logic mode_short;
        logic mode_long;
        logic set_short;
        logic set_long;
        logic combo_hold;
        logic mode_pressed;
        logic set_pressed;
    } t_result;

endpackage

// ===== src/tbpc_in_if.sv =====
// ----------------------------------------------------------------------------
// Tick input channel
// Valid/ready channel that carries the raw levels of both buttons.
// ----------------------------------------------------------------------------
interface tbpc_in_if;
    logic valid;
    logic ready;
    logic mode_level;
    logic set_level;

    modport source (output valid, output mode_level, output set_level, input ready);
    modport sink   (input valid, input mode_level, input set_level, output ready);
endinterface

// ===== src/tbpc_out_if.sv =====
// ----------------------------------------------------------------------------
// Classifier result channel
// Valid/ready channel that carries the event pulses and debounced states.
// ----------------------------------------------------------------------------
interface tbpc_out_if;
    logic valid;
    logic ready;
    logic mode_short;
    logic mode_long;
    logic set_short;
    logic set_long;
    logic combo_hold;
    logic mode_pressed;
    logic set_pressed;

    modport source (output valid, output mode_short, output mode_long, output set_short,
                    output set_long, output combo_hold, output mode_pressed,
                    output set_pressed, input ready);
    modport sink   (input valid, input mode_short, input mode_long, input set_short,
                    input set_long, input combo_hold, input mode_pressed,
                    input set_pressed, output ready);
endinterface

// ===== src/two_button_press_classifier.sv =====
// ----------------------------------------------------------------------------
// Two-button press classifier
// Debounces two active-low buttons and reports short, long and combo presses.
// ----------------------------------------------------------------------------
// Each input item is one millisecond tick with the raw levels of the MODE and
// SET buttons; every item yields exactly one registered result item.
// The block takes one item per clock cycle while input ready is high: both
// button lanes and the combo stage update their state in the cycle the item
// is accepted, and the result lands in an output register backed by a
// one-entry skid register, so a new item is still accepted while one finished
// result waits downstream. Input ready drops only when both the output and
// the skid register are full. The three timing registers are written through
// the plain write port and should only change while no item is in flight.
// ----------------------------------------------------------------------------
module two_button_press_classifier (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tbpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tbpc_pkg::CFG_W-1:0]     i_cfg_data,
    tbpc_in_if.sink                        i_in,
    tbpc_out_if.source                     o_out
);

    tbpc_pkg::t_cfg      r_cfg;
    tbpc_pkg::t_lane_evt mode_evt;
    tbpc_pkg::t_lane_evt set_evt;
    tbpc_pkg::t_result   result;
    tbpc_pkg::t_result   r_out;
    tbpc_pkg::t_result   r_skid;
    logic                r_out_valid;
    logic                r_skid_valid;
    logic                accept;
    logic                pop;

    // Timing registers. An index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= tbpc_pkg::DEBOUNCE_RESET;
            r_cfg.long_press_ticks <= tbpc_pkg::LONG_RESET;
            r_cfg.combo_hold_ticks <= tbpc_pkg::COMBO_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tbpc_pkg::CFG_DEBOUNCE: begin
                    r_cfg.debounce_ticks <= i_cfg_data[tbpc_pkg::DEB_W-1:0];
                end
                tbpc_pkg::CFG_LONG: begin
                    r_cfg.long_press_ticks <= i_cfg_data;
                end
                tbpc_pkg::CFG_COMBO: begin
                    r_cfg.combo_hold_ticks <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // The skid register is the only thing that can block new items.
    assign i_in.ready = !r_skid_valid;
    assign accept     = i_in.valid && !r_skid_valid;
    assign pop        = r_out_valid && o_out.ready;

    // One lane per button; both work on the same item side by side.
    tbpc_lane u_mode_lane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_raw    (i_in.mode_level),
        .i_cfg    (r_cfg),
        .o_evt    (mode_evt)
    );

    tbpc_lane u_set_lane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_raw    (i_in.set_level),
        .i_cfg    (r_cfg),
        .o_evt    (set_evt)
    );

    // The merge stage adds the combo pulse and masks that tick's long pulses.
    tbpc_combo u_combo (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_combo_ticks (r_cfg.combo_hold_ticks),
        .i_mode        (mode_evt),
        .i_set         (set_evt),
        .o_result      (result)
    );

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (r_out_valid && !pop) begin
                r_skid <= result;
            end else begin
                r_out <= result;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.mode_short   = r_out.mode_short;
    assign o_out.mode_long    = r_out.mode_long;
    assign o_out.set_short    = r_out.set_short;
    assign o_out.set_long     = r_out.set_long;
    assign o_out.combo_hold   = r_out.combo_hold;
    assign o_out.mode_pressed = r_out.mode_pressed;
    assign o_out.set_pressed  = r_out.set_pressed;

endmodule

// ===== src/tbpc_lane.sv =====
// ----------------------------------------------------------------------------
// Button lane
// Debounces one active-low button and classifies short and long presses.
// ----------------------------------------------------------------------------
module tbpc_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_raw,
    input  tbpc_pkg::t_cfg     i_cfg,
    output tbpc_pkg::t_lane_evt o_evt
);

    logic                        r_last, n_last;
    logic                        r_stable, n_stable;
    logic [tbpc_pkg::DEB_W-1:0]  r_since, n_since;
    logic [tbpc_pkg::HOLD_W-1:0] r_held, n_held;
    logic                        r_pv, n_pv;
    logic                        r_lr, n_lr;

    logic [tbpc_pkg::HOLD_W-1:0] held_inc;
    logic [tbpc_pkg::HOLD_W-1:0] held_rel;
    logic [tbpc_pkg::HOLD_W-1:0] deb_ext;
    logic                        change;

    assign deb_ext = tbpc_pkg::HOLD_W'(i_cfg.debounce_ticks);

    always_comb begin
        held_inc = r_held;
        if (!r_stable && r_pv && r_held != tbpc_pkg::HOLD_MAX) begin
            held_inc = r_held + 1'b1;
        end

        n_last = i_raw;
        if (i_raw != r_last) begin
            n_since = '0;
        end else if (r_since != tbpc_pkg::DEB_MAX) begin
            n_since = r_since + 1'b1;
        end else begin
            n_since = r_since;
        end

        change = (n_since >= i_cfg.debounce_ticks) && (r_stable != i_raw);

        n_stable     = r_stable;
        n_held       = held_inc;
        n_pv         = r_pv;
        n_lr         = r_lr;
        o_evt.short_ev = 1'b0;
        held_rel     = r_pv ? held_inc : '0;

        if (change) begin
            n_stable = i_raw;
            n_held   = '0;
            n_lr     = 1'b0;
            n_pv     = !i_raw;
            if (i_raw && !r_lr && held_rel >= deb_ext &&
                held_rel < i_cfg.long_press_ticks) begin
                o_evt.short_ev = 1'b1;
            end
        end

        o_evt.long_ev = 1'b0;
        if (!n_stable && !n_lr && n_pv && n_held >= i_cfg.long_press_ticks) begin
            o_evt.long_ev = 1'b1;
            n_lr          = 1'b1;
        end

        o_evt.pressed = !n_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= 1'b1;
            r_stable <= 1'b1;
            r_since  <= '0;
            r_held   <= '0;
            r_pv     <= 1'b0;
            r_lr     <= 1'b0;
        end else if (i_accept) begin
            r_last   <= n_last;
            r_stable <= n_stable;
            r_since  <= n_since;
            r_held   <= n_held;
            r_pv     <= n_pv;
            r_lr     <= n_lr;
        end
    end

endmodule

// ===== src/tbpc_combo.sv =====
// ----------------------------------------------------------------------------
// Combo merge stage
// Combines both lanes: times the joint hold, fires the combo pulse and masks
// the long pulses of the same item.
// ----------------------------------------------------------------------------
module tbpc_combo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [tbpc_pkg::HOLD_W-1:0] i_combo_ticks,
    input  tbpc_pkg::t_lane_evt         i_mode,
    input  tbpc_pkg::t_lane_evt         i_set,
    output tbpc_pkg::t_result           o_result
);

    logic [tbpc_pkg::HOLD_W-1:0] r_count, n_count;
    logic                        r_running, n_running;
    logic                        r_latched, n_latched;
    logic                        fire;

    always_comb begin
        n_running = r_running;
        n_count   = r_count;
        n_latched = r_latched;
        fire      = 1'b0;
        if (i_mode.pressed && i_set.pressed) begin
            if (!r_running) begin
                n_running = 1'b1;
                n_count   = '0;
            end else if (r_count != tbpc_pkg::HOLD_MAX) begin
                n_count = r_count + 1'b1;
            end
            if (!r_latched && n_count >= i_combo_ticks) begin
                fire      = 1'b1;
                n_latched = 1'b1;
            end
        end else begin
            n_running = 1'b0;
            n_count   = '0;
            n_latched = 1'b0;
        end

        o_result.mode_short   = i_mode.short_ev;
        o_result.mode_long    = i_mode.long_ev && !fire;
        o_result.set_short    = i_set.short_ev;
        o_result.set_long     = i_set.long_ev && !fire;
        o_result.combo_hold   = fire;
        o_result.mode_pressed = i_mode.pressed;
        o_result.set_pressed  = i_set.pressed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_running <= 1'b0;
            r_latched <= 1'b0;
        end else if (i_accept) begin
            r_count   <= n_count;
            r_running <= n_running;
            r_latched <= n_latched;
        end
    end

endmodule

// ===== verif/two_button_press_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// Two-button press classifier testbench
// Sends button-level ticks through the input channel, predicts every result
// item with an in-bench model of the debounce and press classification, and
// checks each result item in order under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module two_button_press_classifier_tb;

    // Index that maps to no register; a write to it must change nothing.
    localparam logic [tbpc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Knobs for the random configuration of one phase.
    localparam int CFG_SMALL   = 0;
    localparam int CFG_MINIMUM = 1;
    localparam int CFG_LONGEST = 2;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int DRAIN_SLACK    = 4;
    localparam int HOLD_OFF_TICKS = 60;
    localparam int REPORT_LIMIT   = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [tbpc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [tbpc_pkg::CFG_W-1:0] i_cfg_data;

    tbpc_in_if  tick_if ();
    tbpc_out_if result_if ();

    two_button_press_classifier i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (tick_if),
        .o_out      (result_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Idle percentages for the sender and the receiver. The main sequence
    // changes them between phases only.
    int send_idle_pct;
    int recv_idle_pct;
    // Set by the back-pressure test: the receiver keeps ready low until it has
    // counted this value down to zero itself.
    int hold_off_left;

    int mismatch_count;
    int results_seen;
    int cycle_count;

    // Expected result items, oldest first, one per accepted tick.
    tbpc_pkg::t_result pending_results [$];

    // ------------------------------------------------------------------------
    // Predictor state. It mirrors the timing registers and both button lanes
    // plus the combo stage. Lane 0 is MODE, lane 1 is SET.
    // ------------------------------------------------------------------------
    logic [tbpc_pkg::DEB_W-1:0]  cfg_debounce;
    logic [tbpc_pkg::HOLD_W-1:0] cfg_long;
    logic [tbpc_pkg::HOLD_W-1:0] cfg_combo;

    logic                        lane_raw       [2];
    logic                        lane_stable    [2];
    logic [tbpc_pkg::DEB_W-1:0]  lane_since     [2];
    logic [tbpc_pkg::HOLD_W-1:0] lane_held      [2];
    logic                        lane_press_ok  [2];
    logic                        lane_long_done [2];

    logic [tbpc_pkg::HOLD_W-1:0] combo_cnt;
    logic                        combo_run;
    logic                        combo_lat;

    // Generator state for the random level sequences: the level each lane
    // is heading for and how many more ticks it stays there.
    logic lane_target [2];
    int   run_left    [2];

    function automatic void reset_model();
        cfg_debounce = tbpc_pkg::DEBOUNCE_RESET;
        cfg_long     = tbpc_pkg::LONG_RESET;
        cfg_combo    = tbpc_pkg::COMBO_RESET;
        for (int b = 0; b < 2; b++) begin
            lane_raw[b]       = 1'b1;
            lane_stable[b]    = 1'b1;
            lane_since[b]     = '0;
            lane_held[b]      = '0;
            lane_press_ok[b]  = 1'b0;
            lane_long_done[b] = 1'b0;
            lane_target[b]    = 1'b1;
            run_left[b]       = 0;
        end
        combo_cnt = '0;
        combo_run = 1'b0;
        combo_lat = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [tbpc_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [tbpc_pkg::CFG_W-1:0] data);
        case (idx)
            tbpc_pkg::CFG_DEBOUNCE: begin
                cfg_debounce = data[tbpc_pkg::DEB_W-1:0];
            end
            tbpc_pkg::CFG_LONG: begin
                cfg_long = data[tbpc_pkg::HOLD_W-1:0];
            end
            tbpc_pkg::CFG_COMBO: begin
                cfg_combo = data[tbpc_pkg::HOLD_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // One button lane for one tick: hold counting, debounce, then the short
    // and long classification. The hold counter runs on the old stable level,
    // before this tick's raw level is looked at.
    function automatic void track_lane(input int b, input logic raw,
                                       output logic short_ev, output logic long_ev);
        logic [tbpc_pkg::HOLD_W-1:0] held_len;
        short_ev = 1'b0;
        long_ev  = 1'b0;
        if (!lane_stable[b] && lane_press_ok[b] && lane_held[b] != tbpc_pkg::HOLD_MAX)
            lane_held[b]++;

        if (raw != lane_raw[b]) begin
            lane_raw[b]   = raw;
            lane_since[b] = '0;
        end else if (lane_since[b] != tbpc_pkg::DEB_MAX) begin
            lane_since[b]++;
        end

        if (lane_since[b] >= cfg_debounce && lane_stable[b] != lane_raw[b]) begin
            lane_stable[b] = lane_raw[b];
            if (!lane_stable[b]) begin
                lane_held[b]      = '0;
                lane_press_ok[b]  = 1'b1;
                lane_long_done[b] = 1'b0;
            end else begin
                // A release with no valid press behind it counts as no hold.
                held_len = lane_press_ok[b] ? lane_held[b] : '0;
                if (!lane_long_done[b] && held_len >= cfg_debounce && held_len < cfg_long)
                    short_ev = 1'b1;
                lane_held[b]      = '0;
                lane_press_ok[b]  = 1'b0;
                lane_long_done[b] = 1'b0;
            end
        end

        if (!lane_stable[b] && !lane_long_done[b] && lane_press_ok[b] &&
            lane_held[b] >= cfg_long) begin
            long_ev           = 1'b1;
            lane_long_done[b] = 1'b1;
        end
    endfunction

    // Full prediction for one tick: both lanes, then the combo stage, which
    // masks the long pulses of the tick on which it fires.
    function automatic tbpc_pkg::t_result classify_tick(input logic mode_lvl,
                                                        input logic set_lvl);
        tbpc_pkg::t_result r;
        logic m_short, m_long, s_short, s_long, combo_ev;
        logic both_down;
        combo_ev = 1'b0;
        track_lane(0, mode_lvl, m_short, m_long);
        track_lane(1, set_lvl, s_short, s_long);
        both_down = !lane_stable[0] && !lane_stable[1];
        if (both_down) begin
            if (!combo_run) begin
                combo_run = 1'b1;
                combo_cnt = '0;
            end else if (combo_cnt != tbpc_pkg::HOLD_MAX) begin
                combo_cnt++;
            end
            if (!combo_lat && combo_cnt >= cfg_combo) begin
                combo_ev  = 1'b1;
                combo_lat = 1'b1;
                m_long    = 1'b0;
                s_long    = 1'b0;
            end
        end else begin
            combo_run = 1'b0;
            combo_cnt = '0;
            combo_lat = 1'b0;
        end
        r.mode_short   = m_short;
        r.mode_long    = m_long;
        r.set_short    = s_short;
        r.set_long     = s_long;
        r.combo_hold   = combo_ev;
        r.mode_pressed = !lane_stable[0];
        r.set_pressed  = !lane_stable[1];
        return r;
    endfunction

    // Next raw level of one lane. Levels sit in runs whose length is on the
    // scale of the current timing registers, so presses get debounced and
    // classified; noise_pct flips single ticks to make bounce.
    function automatic logic next_raw(input int b, input int noise_pct);
        int span;
        span = int'(cfg_long) + 2 * int'(cfg_debounce) + 6;
        if (span > 120)
            span = 120;
        if (run_left[b] == 0) begin
            lane_target[b] = ~lane_target[b];
            run_left[b]    = $urandom_range(span, 0);
        end else begin
            run_left[b]--;
        end
        return ($urandom_range(99) < noise_pct) ? ~lane_target[b] : lane_target[b];
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers. Everything is driven at the falling edge; handshakes
    // are sampled at the rising edge.
    // ------------------------------------------------------------------------

    // Offers one tick, possibly after a few idle cycles, and records its
    // prediction once the block has taken it. Valid is left high so that a
    // following tick goes out back to back.
    task automatic send_tick(input logic mode_lvl, input logic set_lvl);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            tick_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        tick_if.valid      <= 1'b1;
        tick_if.mode_level <= mode_lvl;
        tick_if.set_level  <= set_lvl;
        @(posedge i_clk);
        while (tick_if.ready !== 1'b1)
            @(posedge i_clk);
        pending_results.push_back(classify_tick(mode_lvl, set_lvl));
    endtask

    // Stops offering ticks and waits until every predicted result item has
    // come out, then lets the output pipeline settle.
    task automatic wait_drained();
        @(negedge i_clk);
        tick_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tbpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tbpc_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset timing: a few ticks of both levels, far too short to debounce.
    task automatic test_defaults();
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
    endtask

    // No debounce and short timers: a MODE short press, then a joint hold
    // on which the combo and both long presses land on the same tick, so the
    // long pulses are masked; the release after it reports no short press.
    // A write to the unused index goes in after the timing writes and must not matter.
    task automatic test_short_long_combo();
        wait_drained();
        write_reg(tbpc_pkg::CFG_DEBOUNCE, tbpc_pkg::CFG_W'(0));
        write_reg(tbpc_pkg::CFG_LONG, tbpc_pkg::CFG_W'(3));
        write_reg(tbpc_pkg::CFG_COMBO, tbpc_pkg::CFG_W'(3));
        write_reg(CFG_UNUSED, tbpc_pkg::CFG_W'('hFFFF));
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        repeat (5) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
    endtask

    // Zero long time fires the long press on the tick the press is taken and
    // never allows a short one; zero combo time fires on the first joint
    // tick. A one-tick debounce swallows the single-tick bounce on MODE.
    task automatic test_zero_times();
        wait_drained();
        write_reg(tbpc_pkg::CFG_DEBOUNCE, tbpc_pkg::CFG_W'(1));
        write_reg(tbpc_pkg::CFG_LONG, tbpc_pkg::CFG_W'(0));
        write_reg(tbpc_pkg::CFG_COMBO, tbpc_pkg::CFG_W'(0));
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
    endtask

    // Largest debounce (written with the upper data bits set, which the
    // 10-bit register drops), a long time of one tick and largest combo time.
    task automatic test_slow_extremes();
        wait_drained();
        write_reg(tbpc_pkg::CFG_DEBOUNCE, tbpc_pkg::CFG_W'('hFFFF));
        write_reg(tbpc_pkg::CFG_LONG, tbpc_pkg::CFG_W'(1));
        write_reg(tbpc_pkg::CFG_COMBO, tbpc_pkg::HOLD_MAX);
        repeat (3) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
    endtask

    // The receiver holds ready low for a long stretch while ticks keep
    // coming, so the output and skid registers fill and input ready drops.
    task automatic test_receiver_hold_off();
        wait_drained();
        @(posedge i_clk);
        hold_off_left = HOLD_OFF_TICKS;
        repeat (24) send_tick(next_raw(0, 5), next_raw(1, 5));
    endtask

    // One random phase: a fresh configuration, then press sequences in
    // chunks that are mostly clean and sometimes heavy with bounce.
    task automatic test_random_phase(input int n_items, input int cfg_kind);
        logic [tbpc_pkg::DEB_W-1:0]  deb;
        logic [tbpc_pkg::HOLD_W-1:0] long_t;
        logic [tbpc_pkg::HOLD_W-1:0] combo_t;
        int noise_pct;
        wait_drained();
        case (cfg_kind)
            CFG_MINIMUM: begin
                deb     = '0;
                long_t  = tbpc_pkg::HOLD_W'(1);
                combo_t = '0;
            end
            CFG_LONGEST: begin
                deb     = tbpc_pkg::DEB_W'($urandom_range(3, 0));
                long_t  = tbpc_pkg::HOLD_MAX;
                combo_t = tbpc_pkg::HOLD_MAX;
            end
            default: begin
                deb     = tbpc_pkg::DEB_W'($urandom_range(4, 0));
                long_t  = tbpc_pkg::HOLD_W'($urandom_range(25, 1));
                combo_t = tbpc_pkg::HOLD_W'($urandom_range(30, 0));
            end
        endcase
        write_reg(tbpc_pkg::CFG_DEBOUNCE, {6'($urandom_range(63, 0)), deb});
        write_reg(tbpc_pkg::CFG_LONG, long_t);
        write_reg(tbpc_pkg::CFG_COMBO, combo_t);
        write_reg(CFG_UNUSED, tbpc_pkg::CFG_W'($urandom_range(65535, 0)));
        noise_pct = 5;
        for (int i = 0; i < n_items; i++) begin
            if (i % 30 == 0)
                noise_pct = ($urandom_range(99) < 80) ? 5 : 50;
            send_tick(next_raw(0, noise_pct), next_raw(1, noise_pct));
        end
    endtask

    // Both buttons held for a long stretch with the largest long and combo
    // times: neither a long press nor the combo fires, and the release
    // reports a short press on each button.
    task automatic test_long_joint_hold();
        wait_drained();
        write_reg(tbpc_pkg::CFG_DEBOUNCE, tbpc_pkg::CFG_W'(0));
        write_reg(tbpc_pkg::CFG_LONG, tbpc_pkg::HOLD_MAX);
        write_reg(tbpc_pkg::CFG_COMBO, tbpc_pkg::HOLD_MAX);
        repeat (30) send_tick(1'b0, 1'b0);
        repeat (3) send_tick(1'b1, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready changes at the falling edge, either held low by the
    // hold-off count or idling at random at the current percentage.
    // ------------------------------------------------------------------------
    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                result_if.ready <= 1'b0;
                hold_off_left--;
            end else begin
                result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Every accepted result item is compared with the oldest prediction.
    // A result item with nothing predicted is a failure as well.
    always @(posedge i_clk) begin : result_checker
        tbpc_pkg::t_result got;
        tbpc_pkg::t_result want;
        if (i_rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            got.mode_short   = result_if.mode_short;
            got.mode_long    = result_if.mode_long;
            got.set_short    = result_if.set_short;
            got.set_long     = result_if.set_long;
            got.combo_hold   = result_if.combo_hold;
            got.mode_pressed = result_if.mode_pressed;
            got.set_pressed  = result_if.set_pressed;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result item %0d arrived with none expected: %b",
                             results_seen, got);
            end else begin
                want = pending_results.pop_front();
                if (got.mode_short !== want.mode_short || got.mode_long !== want.mode_long ||
                    got.set_short !== want.set_short || got.set_long !== want.set_long ||
                    got.combo_hold !== want.combo_hold ||
                    got.mode_pressed !== want.mode_pressed ||
                    got.set_pressed !== want.set_pressed) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"result item %0d mismatch (ms ml ss sl combo mp sp):",
                                  " expected %b %b %b %b %b %b %b, got %b %b %b %b %b %b %b"},
                                 results_seen,
                                 want.mode_short, want.mode_long, want.set_short,
                                 want.set_long, want.combo_hold, want.mode_pressed,
                                 want.set_pressed,
                                 got.mode_short, got.mode_long, got.set_short,
                                 got.set_long, got.combo_hold, got.mode_pressed,
                                 got.set_pressed);
                end
            end
            results_seen++;
        end
    end

    // Watchdog: a run that has not finished well past the slowest correct
    // run is stuck.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence. Three idling phases: receiver-heavy stalls first, then
    // sender-heavy gaps, then full rate. Configuration changes happen
    // only once all predicted result items have drained.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = tbpc_pkg::CFG_DEBOUNCE;
        i_cfg_data         = '0;
        tick_if.valid      = 1'b0;
        tick_if.mode_level = 1'b1;
        tick_if.set_level  = 1'b1;
        hold_off_left      = 0;
        mismatch_count     = 0;
        results_seen       = 0;
        send_idle_pct      = 37;
        recv_idle_pct      = 69;
        reset_model();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_short_long_combo();
        test_zero_times();
        test_slow_extremes();
        test_random_phase(80, CFG_SMALL);
        test_receiver_hold_off();
        test_random_phase(80, CFG_MINIMUM);

        wait_drained();
        send_idle_pct = 69;
        recv_idle_pct = 37;
        test_random_phase(80, CFG_SMALL);
        test_random_phase(80, CFG_LONGEST);

        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_phase(90, CFG_SMALL);
        test_long_joint_hold();
        test_random_phase(80, CFG_SMALL);

        wait_drained();
        repeat (DRAIN_SLACK) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
